@@ design/srlu_pkg.sv @@
package srlu_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int AW          = $clog2(MAX_ENTRIES);
  localparam int CW          = AW + 1;
  localparam int KW          = 32;
  localparam int VW          = 64;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK,
    ST_UPD_END,
    ST_COMMIT,
    ST_COMMIT_END
  } state_e;

  typedef struct packed {
    logic          key_we;
    logic          val_we;
    logic          stg_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] val_waddr;
    logic [AW-1:0] raddr;
  } store_ctl_t;

endpackage

@@ design/sorted_record_lookup_update.sv @@
// channel   | ports                                               | handshake
// ----------+-----------------------------------------------------+------------------------
// command   | mode_i position_i key_i item_value_i last_i         | start_i while !busy_o
// result    | hit_o read_value_o done_res_o update_ok_o           | result_valid_o, 1 cycle
//           | missing_key_o                                       |
// config    | entry_count_i                                       | entry_count_we_i
//
// load, unused mode, and lookup on an empty table: answered straight from idle. lookup
// otherwise: a binary search, one key memory read per probe.
// update pair: straight to the end state when already failed or the cursor is at the end,
// else a walk with one key memory read per entry, until a key not below the pair's key.
// last pair of a good update: the pair's steps, then a commit sweep over all
// 256 staged slots.
// reset clears control state and the staged mask; memories hold no reset value.
// the receiver cannot stall: each result is shown for exactly one cycle.
module sorted_record_lookup_update
  import srlu_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    position_i,
  input  logic [KW-1:0] key_i,
  input  logic [VW-1:0] item_value_i,
  input  logic          last_i,
  input  logic          entry_count_we_i,
  input  logic [7:0]    entry_count_i,
  output logic          result_valid_o,
  output logic          hit_o,
  output logic [VW-1:0] read_value_o,
  output logic          done_res_o,
  output logic          update_ok_o,
  output logic [KW-1:0] missing_key_o
);

  state_e               state_q, state_d;
  logic [KW-1:0]        key_q, key_d;
  logic [VW-1:0]        val_q, val_d;
  logic                 last_q, last_d;
  logic [7:0]           cnt_q;
  logic [CW-1:0]        lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]        cur_q, cur_d;
  logic                 failed_q, failed_d;
  logic [KW-1:0]        miss_q, miss_d;
  logic [MAX_ENTRIES-1:0] mask_q, mask_d;
  logic [AW-1:0]        sweep_q, sweep_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;

  logic                 rv_q, rv_d, hit_q, hit_d, done_q, done_d, ok_q, ok_d;
  logic [VW-1:0]        rval_q, rval_d;
  logic [KW-1:0]        mkey_q, mkey_d;

  store_ctl_t           ctl;
  logic [KW-1:0]        key_rd;
  logic [VW-1:0]        val_rd, stg_rd;
  logic [VW-1:0]        val_wdata;
  logic [CW-1:0]        cnt_ext, cur_inc, lo_n, hi_n;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;

  assign cnt_ext = {1'b0, cnt_q};
  assign cur_inc = cur_q + CW'(1);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
  assign mid     = mid_sum[CW:1];

  srlu_store u_store (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .key_wdata_i (key_i),
    .val_wdata_i (val_wdata),
    .stg_wdata_i (val_q),
    .key_rdata_o (key_rd),
    .val_rdata_o (val_rd),
    .stg_rdata_o (stg_rd)
  );

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    val_d     = val_q;
    last_d    = last_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    cur_d     = cur_q;
    failed_d  = failed_q;
    miss_d    = miss_q;
    mask_d    = mask_q;
    sweep_d   = sweep_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    rv_d      = 1'b0;
    hit_d     = 1'b0;
    rval_d    = '0;
    done_d    = 1'b0;
    ok_d      = 1'b0;
    mkey_d    = '0;
    lo_n      = lo_q;
    hi_n      = hi_q;
    ctl           = '0;
    ctl.waddr     = cur_q[AW-1:0];
    ctl.val_waddr = wr_addr_q;
    ctl.raddr     = cur_q[AW-1:0];
    val_wdata     = stg_rd;
    ctl.val_we    = wr_pend_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d  = key_i;
          val_d  = item_value_i;
          last_d = last_i;
          case (mode_i)
            MODE_LOAD: begin
              ctl.key_we    = 1'b1;
              ctl.val_we    = 1'b1;
              ctl.waddr     = position_i;
              ctl.val_waddr = position_i;
              val_wdata     = item_value_i;
              rv_d          = 1'b1;
            end
            MODE_LOOKUP: begin
              if (cnt_q == 8'd0) begin
                rv_d = 1'b1;
              end else begin
                lo_d      = '0;
                hi_d      = cnt_ext;
                ctl.raddr = AW'((cnt_ext - CW'(1)) >> 1);
                state_d   = ST_SEARCH;
              end
            end
            MODE_UPDATE: begin
              if (failed_q) begin
                state_d = ST_UPD_END;
              end else if (cur_q >= cnt_ext) begin
                failed_d = 1'b1;
                miss_d   = key_i;
                state_d  = ST_UPD_END;
              end else begin
                ctl.raddr = cur_q[AW-1:0];
                state_d   = ST_WALK;
              end
            end
            default: begin
              rv_d = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (key_rd == key_q) begin
          rv_d    = 1'b1;
          hit_d   = 1'b1;
          rval_d  = val_rd;
          state_d = ST_IDLE;
        end else begin
          if (key_rd < key_q) begin
            lo_n = mid + CW'(1);
          end else begin
            hi_n = mid;
          end
          lo_d = lo_n;
          hi_d = hi_n;
          if (lo_n < hi_n) begin
            ctl.raddr = AW'((({1'b0, lo_n} + {1'b0, hi_n} - (CW+1)'(1)) >> 1));
          end else begin
            rv_d    = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        if (key_rd < key_q) begin
          if (cur_inc >= cnt_ext) begin
            cur_d    = cur_inc;
            failed_d = 1'b1;
            miss_d   = key_q;
            state_d  = ST_UPD_END;
          end else begin
            cur_d     = cur_inc;
            ctl.raddr = cur_inc[AW-1:0];
          end
        end else if (key_rd == key_q) begin
          ctl.stg_we                 = 1'b1;
          ctl.waddr                  = cur_q[AW-1:0];
          mask_d[cur_q[AW-1:0]]      = 1'b1;
          cur_d                      = cur_inc;
          state_d                    = ST_UPD_END;
        end else begin
          failed_d = 1'b1;
          miss_d   = key_q;
          state_d  = ST_UPD_END;
        end
      end
      ST_UPD_END: begin
        if (!last_q) begin
          rv_d    = 1'b1;
          state_d = ST_IDLE;
        end else if (failed_q) begin
          rv_d     = 1'b1;
          done_d   = 1'b1;
          mkey_d   = miss_q;
          mask_d   = '0;
          cur_d    = '0;
          failed_d = 1'b0;
          miss_d   = '0;
          state_d  = ST_IDLE;
        end else begin
          sweep_d = '0;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctl.raddr = sweep_q;
        wr_pend_d = mask_q[sweep_q];
        wr_addr_d = sweep_q;
        sweep_d   = sweep_q + AW'(1);
        if (sweep_q == AW'(MAX_ENTRIES - 1)) begin
          state_d = ST_COMMIT_END;
        end
      end
      ST_COMMIT_END: begin
        rv_d     = 1'b1;
        done_d   = 1'b1;
        ok_d     = 1'b1;
        mask_d   = '0;
        cur_d    = '0;
        failed_d = 1'b0;
        miss_d   = '0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cur_q     <= '0;
      failed_q  <= 1'b0;
      miss_q    <= '0;
      mask_q    <= '0;
      sweep_q   <= '0;
      wr_pend_q <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (entry_count_we_i) begin
        cnt_q <= entry_count_i;
      end
      cur_q     <= cur_d;
      failed_q  <= failed_d;
      miss_q    <= miss_d;
      mask_q    <= mask_d;
      sweep_q   <= sweep_d;
      wr_pend_q <= wr_pend_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    val_q     <= val_d;
    last_q    <= last_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    wr_addr_q <= wr_addr_d;
    hit_q     <= hit_d;
    rval_q    <= rval_d;
    done_q    <= done_d;
    ok_q      <= ok_d;
    mkey_q    <= mkey_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = rv_q;
  assign hit_o          = hit_q;
  assign read_value_o   = rval_q;
  assign done_res_o     = done_q;
  assign update_ok_o    = ok_q;
  assign missing_key_o  = mkey_q;

endmodule

@@ design/srlu_store.sv @@
module srlu_store
  import srlu_pkg::*;
(
  input  logic          clk_i,
  input  store_ctl_t    ctl_i,
  input  logic [KW-1:0] key_wdata_i,
  input  logic [VW-1:0] val_wdata_i,
  input  logic [VW-1:0] stg_wdata_i,
  output logic [KW-1:0] key_rdata_o,
  output logic [VW-1:0] val_rdata_o,
  output logic [VW-1:0] stg_rdata_o
);

  logic [KW-1:0] key_mem [MAX_ENTRIES];
  logic [VW-1:0] val_mem [MAX_ENTRIES];
  logic [VW-1:0] stg_mem [MAX_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[ctl_i.waddr] <= key_wdata_i;
    end
    key_rdata_o <= key_mem[ctl_i.raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[ctl_i.val_waddr] <= val_wdata_i;
    end
    val_rdata_o <= val_mem[ctl_i.raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.stg_we) begin
      stg_mem[ctl_i.waddr] <= stg_wdata_i;
    end
    stg_rdata_o <= stg_mem[ctl_i.raddr];
  end

endmodule

@@ test/sorted_record_lookup_update_checker.sv @@
module sorted_record_lookup_update_checker
  import srlu_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    position_i,
  input  logic [KW-1:0] key_i,
  input  logic [VW-1:0] item_value_i,
  input  logic          last_i,
  input  logic          entry_count_we_i,
  input  logic [7:0]    entry_count_i,
  input  logic          result_valid_i,
  input  logic          hit_i,
  input  logic [VW-1:0] read_value_i,
  input  logic          done_res_i,
  input  logic          update_ok_i,
  input  logic [KW-1:0] missing_key_i,
  output int            fail_count_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic          hit;
    logic [VW-1:0] read_value;
    logic          done_res;
    logic          update_ok;
    logic [KW-1:0] missing_key;
  } outcome_t;

  logic [KW-1:0] rec_keys [MAX_ENTRIES];
  logic [VW-1:0] rec_vals [MAX_ENTRIES];
  logic [VW-1:0] staged [MAX_ENTRIES];
  logic          staged_mask [MAX_ENTRIES];
  logic [CW-1:0] cursor;
  logic          failed;
  logic [KW-1:0] first_missing;
  logic [7:0]    count;
  outcome_t      outcome_q [$];

  assign pending_o = outcome_q.size();

  task automatic report(input string what, input logic [VW-1:0] got, input logic [VW-1:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic clear_update();
    foreach (staged_mask[i]) staged_mask[i] = 1'b0;
    cursor = '0;
    failed = 1'b0;
    first_missing = '0;
  endtask

  function automatic outcome_t lookup_outcome(logic [KW-1:0] key);
    outcome_t o;
    int lo, hi, mid;
    o = '0;
    lo = 0;
    hi = int'(count) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (rec_keys[mid] == key) begin
        o.hit = 1'b1;
        o.read_value = rec_vals[mid];
        break;
      end else if (rec_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return o;
  endfunction

  task automatic apply_transaction(input mode_e mode, input logic [7:0] pos,
                                   input logic [KW-1:0] key, input logic [VW-1:0] val,
                                   input logic last);
    outcome_t o;
    o = '0;
    case (mode)
      MODE_LOAD: begin
        rec_keys[pos] = key;
        rec_vals[pos] = val;
      end
      MODE_LOOKUP: o = lookup_outcome(key);
      MODE_UPDATE: begin
        if (!failed) begin
          while (cursor < count && rec_keys[cursor] < key) cursor++;
          if (cursor >= count || rec_keys[cursor] != key) begin
            failed = 1'b1;
            first_missing = key;
          end else begin
            staged[cursor] = val;
            staged_mask[cursor] = 1'b1;
            cursor++;
          end
        end
        if (last) begin
          o.done_res = 1'b1;
          if (!failed) begin
            foreach (staged_mask[i]) if (staged_mask[i]) rec_vals[i] = staged[i];
            o.update_ok = 1'b1;
          end else begin
            o.missing_key = first_missing;
          end
          clear_update();
        end
      end
      default: ;
    endcase
    outcome_q.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      count = '0;
      clear_update();
    end else begin
      if (result_valid_i) begin
        if (outcome_q.size() == 0) begin
          report("unexpected result", '0, '0);
        end else begin
          want = outcome_q.pop_front();
          if (hit_i !== want.hit) report("hit", hit_i, want.hit);
          if (read_value_i !== want.read_value)
            report("read_value", read_value_i, want.read_value);
          if (done_res_i !== want.done_res) report("done_res", done_res_i, want.done_res);
          if (update_ok_i !== want.update_ok) report("update_ok", update_ok_i, want.update_ok);
          if (missing_key_i !== want.missing_key)
            report("missing_key", missing_key_i, want.missing_key);
        end
      end
      if (start_i && !busy_i)
        apply_transaction(mode_e'(mode_i), position_i, key_i, item_value_i, last_i);
      if (entry_count_we_i) count = entry_count_i;
    end
  end

endmodule

@@ test/sorted_record_lookup_update_tb.sv @@
module sorted_record_lookup_update_tb;
  import srlu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    mode = MODE_NOP;
  logic [7:0]    position = '0;
  logic [KW-1:0] key = '0;
  logic [VW-1:0] item_value = '0;
  logic          last = 1'b0;
  logic          count_we = 1'b0;
  logic [7:0]    count_val = '0;
  logic          result_valid;
  logic          hit;
  logic [VW-1:0] read_value;
  logic          done_res;
  logic          update_ok;
  logic [KW-1:0] missing_key;
  int            fail_count;
  int            pending;
  int            idle_cycles = 0;

  logic [KW-1:0] loaded_keys [MAX_ENTRIES];
  logic [7:0]    cur_count = '0;
  bit            no_gaps = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_record_lookup_update dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .mode_i(mode), .position_i(position), .key_i(key), .item_value_i(item_value),
    .last_i(last), .entry_count_we_i(count_we), .entry_count_i(count_val),
    .result_valid_o(result_valid), .hit_o(hit), .read_value_o(read_value),
    .done_res_o(done_res), .update_ok_o(update_ok), .missing_key_o(missing_key)
  );

  sorted_record_lookup_update_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .mode_i(mode), .position_i(position), .key_i(key), .item_value_i(item_value),
    .last_i(last), .entry_count_we_i(count_we), .entry_count_i(count_val),
    .result_valid_i(result_valid), .hit_i(hit), .read_value_i(read_value),
    .done_res_i(done_res), .update_ok_i(update_ok), .missing_key_i(missing_key),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [VW-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  task automatic send(input mode_e m, input logic [7:0] pos, input logic [KW-1:0] k,
                      input logic [VW-1:0] v, input logic l);
    int gap;
    start <= 1'b1;
    mode <= m;
    position <= pos;
    key <= k;
    item_value <= v;
    last <= l;
    if (m == MODE_LOAD) loaded_keys[pos] = k;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    gap = $urandom_range(1, 3);
        3:          gap = $urandom_range(10, 40);
        default:    gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(input logic [7:0] c);
    drain();
    count_we <= 1'b1;
    count_val <= c;
    cur_count = c;
    @(posedge clk);
    count_we <= 1'b0;
  endtask

  // ascending run of present keys, optionally broken by an absent, earlier or random key
  task automatic update_sequence(input int broken);
    int idx, n, pairs, bad_at;
    logic [KW-1:0] k;
    n = cur_count;
    pairs = $urandom_range(1, 6);
    bad_at = broken ? $urandom_range(0, pairs - 1) : -1;
    idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int p = 0; p < pairs; p++) begin
      k = loaded_keys[idx];
      if (p == bad_at) begin
        case ($urandom_range(0, 2))
          0: k = loaded_keys[idx] + 1;
          1: k = (idx > 0) ? loaded_keys[idx - 1] : loaded_keys[idx] + 1;
          default: k = $urandom;
        endcase
      end
      send(MODE_UPDATE, '0, k, rand_value(), p == pairs - 1);
      if (idx + 1 < n) idx = idx + $urandom_range(1, 3);
      if (idx >= n) idx = (n > 0) ? n - 1 : 0;
    end
  endtask

  initial begin
    logic [KW-1:0] k;
    logic [7:0]    pos_r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_count(8'd0);
    send(MODE_LOOKUP, 8'hff, '1, '1, 1'b1);
    send(MODE_UPDATE, 8'hff, 32'h1234_5678, '1, 1'b1);
    send(MODE_NOP, 8'hff, '1, '1, 1'b1);

    // fill every slot with ascending keys, both key extremes present
    k = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i == MAX_ENTRIES - 1) k = '1;
      send(MODE_LOAD, i[7:0], k, (i == 0) ? '1 : rand_value(), i[0]);
      k = k + $urandom_range(1, 1 << 24);
    end

    set_count(8'd255);
    send(MODE_LOOKUP, '0, 32'h0, '0, 1'b0);
    send(MODE_LOOKUP, '0, loaded_keys[254], '0, 1'b0);
    send(MODE_LOOKUP, '0, '1, '0, 1'b0);
    send(MODE_LOOKUP, '0, loaded_keys[100] + 1, '0, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[0], '1, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[5], 64'h0, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[254], 64'h8000_0000_0000_0001, 1'b1);
    send(MODE_LOOKUP, '0, loaded_keys[254], '0, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[10], '1, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[10], '1, 1'b1);
    send(MODE_UPDATE, '0, loaded_keys[20], '1, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[15], '1, 1'b1);
    send(MODE_UPDATE, '0, loaded_keys[30] + 1, '1, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[40], '1, 1'b0);
    send(MODE_LOAD, 8'd40, loaded_keys[40], 64'h5555_aaaa_5555_aaaa, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[50], '1, 1'b1);
    send(MODE_LOOKUP, '0, loaded_keys[40], '0, 1'b0);
    set_count(8'd1);
    send(MODE_LOOKUP, '0, loaded_keys[0], '0, 1'b0);
    send(MODE_UPDATE, '0, loaded_keys[1], '0, 1'b1);
    send(MODE_UPDATE, '0, loaded_keys[0], 64'h1, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_count(8'd255);
        1: set_count(8'd2);
        2: set_count(8'd0);
        default: set_count(8'($urandom_range(1, 255)));
      endcase
      no_gaps = (phase == 3);
      repeat (25) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: begin
            if (cur_count > 0 && $urandom_range(0, 3) != 0)
              k = loaded_keys[$urandom_range(0, cur_count - 1)];
            else
              k = $urandom;
            send(MODE_LOOKUP, 8'($urandom), k, rand_value(), 1'($urandom_range(0, 1)));
          end
          6, 7, 8, 9, 10, 11, 12: update_sequence(0);
          13, 14: update_sequence(1);
          15, 16: begin
            pos_r = 8'($urandom);
            send(MODE_LOAD, pos_r, loaded_keys[pos_r], rand_value(),
                 1'($urandom_range(0, 1)));
          end
          17: send(MODE_LOAD, 8'($urandom), $urandom, rand_value(),
                   1'($urandom_range(0, 1)));
          18: send(MODE_NOP, 8'($urandom), $urandom, rand_value(),
                   1'($urandom_range(0, 1)));
          default: send(MODE_UPDATE, '0, $urandom, rand_value(), 1'($urandom_range(0, 1)));
        endcase
      end
    end
    // close any sequence still open
    send(MODE_UPDATE, '0, '0, '0, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/srlu_pkg.sv
design/srlu_store.sv
design/sorted_record_lookup_update.sv
test/sorted_record_lookup_update_checker.sv
test/sorted_record_lookup_update_tb.sv
